[hw/rtl/rrqs_pkg.sv]
// Shared types and constants for the round-robin quantum scheduler.
// Holds the request and response structs, mode codes and reset values.
// No dependencies.
package rrqs_pkg;

    localparam int ID_W           = 4;
    localparam int ID_SLOTS       = 16;
    localparam int TICK_W         = 16;
    localparam int COUNT_W        = 5;
    localparam int TASK_COUNT_DEF = 16;

    localparam logic [TICK_W-1:0] DEFAULT_TICKS = 16'd30;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_READY   = 2'd1;
    localparam logic [1:0] MODE_QUANTUM = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] quantum_value;
    } req_t;

    typedef struct packed {
        logic               switched;
        logic [ID_W-1:0]    running_task;
        logic [TICK_W-1:0]  ticks_left;
        logic [COUNT_W-1:0] ready_count;
        logic               overflow;
    } rsp_t;

endpackage

[hw/rtl/round_robin_quantum_scheduler_unit.sv]
// Round-robin scheduler with per-task quantum; depends on rrqs_pkg and rrqs_ram.
// The response is registered from S_POP, or from S_LOAD for a tick that reloads a quantum
// (queue memory read, then quantum memory read) or while the output is stalled. One
// request at a time: the next is taken once the response is registered.
// Reset: pointers, fill, countdown (30) and running task (0) clear at once; the
// quantum table reads 30 per task until written, the queue needs no clearing.
module round_robin_quantum_scheduler_unit
    import rrqs_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] cfg_data,
    input  logic            req_valid,
    output logic            req_ready,
    input  req_t            req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rsp_t            rsp_data
);

    localparam int PTR_W  = $clog2(TASK_COUNT);
    localparam int FILL_W = $clog2(TASK_COUNT + 1);
    localparam int SLOT_W = $clog2(ID_SLOTS);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(TASK_COUNT - 1);
    localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(TASK_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]          state_reg,     state_next;
    logic [ID_W-1:0]     idle_id_reg,   idle_id_next;
    logic [PTR_W-1:0]    head_reg,      head_next;
    logic [PTR_W-1:0]    tail_reg,      tail_next;
    logic [FILL_W-1:0]   fill_reg,      fill_next;
    logic [ID_W-1:0]     running_reg,   running_next;
    logic [TICK_W-1:0]   countdown_reg, countdown_next;
    logic [ID_SLOTS-1:0] qvalid_reg,    qvalid_next;
    req_t                req_reg,       req_next;
    logic                sw_reg,        sw_next;
    logic                ovf_reg,       ovf_next;
    logic                reload_reg,    reload_next;
    logic                qhit_reg,      qhit_next;
    rsp_t                rsp_reg,       rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic              q_wr_en;
    logic [ID_W-1:0]   q_wr_data;
    logic              q_rd_en;
    logic [ID_W-1:0]   q_rd_data;
    logic              qt_wr_en;
    logic              qt_rd_en;
    logic [ID_W-1:0]   qt_rd_addr;
    logic [TICK_W-1:0] qt_rd_data;
    logic [TICK_W-1:0] cd_dec;
    logic [TICK_W-1:0] cd_load;
    logic              is_idle;
    logic              out_free;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    rrqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (TASK_COUNT)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    rrqs_ram #(
        .WIDTH (TICK_W),
        .DEPTH (ID_SLOTS)
    ) u_quantum_ram (
        .clk     (clk),
        .wr_en   (qt_wr_en),
        .wr_addr (SLOT_W'(req_reg.task_id)),
        .wr_data (req_reg.quantum_value),
        .rd_en   (qt_rd_en),
        .rd_addr (SLOT_W'(qt_rd_addr)),
        .rd_data (qt_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign cd_dec   = countdown_reg - TICK_W'(1);
    assign is_idle  = (running_reg == idle_id_reg);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign cd_load  = reload_reg ? (qhit_reg ? qt_rd_data : DEFAULT_TICKS) : countdown_reg;

    always_comb
    begin
        state_next     = state_reg;
        idle_id_next   = cfg_valid ? cfg_data : idle_id_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        running_next   = running_reg;
        countdown_next = countdown_reg;
        qvalid_next    = qvalid_reg;
        req_next       = req_reg;
        sw_next        = sw_reg;
        ovf_next       = ovf_reg;
        reload_next    = reload_reg;
        qhit_next      = qhit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        q_wr_en        = 1'b0;
        q_wr_data      = running_reg;
        q_rd_en        = 1'b0;
        qt_wr_en       = 1'b0;
        qt_rd_en       = 1'b0;
        qt_rd_addr     = running_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    // fetch the queue head alongside the request
                    req_next   = req_data;
                    q_rd_en    = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                sw_next     = 1'b0;
                ovf_next    = 1'b0;
                reload_next = 1'b0;
                unique case (req_reg.mode)
                    MODE_TICK:
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0 || is_idle)
                        begin
                            reload_next = 1'b1;
                            qt_rd_en    = 1'b1;
                            if (fill_reg != '0)
                            begin
                                // pop before push, so a full queue never overflows
                                running_next = q_rd_data;
                                qt_rd_addr   = q_rd_data;
                                head_next    = ptr_adv(head_reg);
                                sw_next      = 1'b1;
                                if (!is_idle)
                                begin
                                    q_wr_en   = 1'b1;
                                    tail_next = ptr_adv(tail_reg);
                                end
                                else
                                begin
                                    fill_next = fill_reg - FILL_W'(1);
                                end
                            end
                            else
                            begin
                                sw_next = !is_idle;
                            end
                        end
                    end
                    MODE_READY:
                    begin
                        if (req_reg.task_id != idle_id_reg)
                        begin
                            if (fill_reg == FILL_CAP)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                q_wr_en   = 1'b1;
                                q_wr_data = req_reg.task_id;
                                tail_next = ptr_adv(tail_reg);
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                    end
                    MODE_QUANTUM:
                    begin
                        qt_wr_en = 1'b1;
                        qvalid_next[SLOT_W'(req_reg.task_id)] = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                qhit_next = qvalid_reg[SLOT_W'(qt_rd_addr)];
                if (!reload_next && out_free)
                begin
                    rsp_next.switched     = 1'b0;
                    rsp_next.running_task = running_next;
                    rsp_next.ticks_left   = countdown_next;
                    rsp_next.ready_count  = COUNT_W'(fill_next);
                    rsp_next.overflow     = ovf_next;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    countdown_next        = cd_load;
                    rsp_next.switched     = sw_reg;
                    rsp_next.running_task = running_reg;
                    rsp_next.ticks_left   = cd_load;
                    rsp_next.ready_count  = COUNT_W'(fill_reg);
                    rsp_next.overflow     = ovf_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idle_id_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            running_reg   <= '0;
            countdown_reg <= DEFAULT_TICKS;
            qvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idle_id_reg   <= idle_id_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            running_reg   <= running_next;
            countdown_reg <= countdown_next;
            qvalid_reg    <= qvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        sw_reg     <= sw_next;
        ovf_reg    <= ovf_next;
        reload_reg <= reload_next;
        qhit_reg   <= qhit_next;
        rsp_reg    <= rsp_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_CAP)
        else $error("ready queue fill beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0 || fill_reg == FILL_CAP) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.switched && rsp_reg.overflow))
        else $error("switch and overflow in one response");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == S_POP)
        else $error("accepted request did not start queue read");

endmodule

[hw/rtl/rrqs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the ready queue and the quantum table. No dependencies.
module rrqs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
